/* design/prqs_pkg.sv */
// ----------------------------------------------------------------------------
// prqs_pkg: shared types and constants for the priority ready queue scheduler
// Queue depth, field widths, event and status codes, cell command and link types.
// ----------------------------------------------------------------------------
package prqs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_W        = 8;
   localparam int PRIO_W      = 8;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int RCOUNT_W    = 5;

   // event kinds carried on the request side
   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE    = 2'd0,
      FUNC_YIELD     = 2'd1,
      FUNC_TERMINATE = 2'd2
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // operation broadcast to every cell of the queue
   typedef enum logic [1:0] {
      OP_HOLD       = 2'd0,
      OP_INSERT     = 2'd1,
      OP_POP        = 2'd2,
      OP_POP_INSERT = 2'd3
   } cell_op_type;

   // one queue entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // command from the controller to all cells
   typedef struct packed {
      cell_op_type       op;
      logic [PRIO_W-1:0] key;
      entry_type         fresh;
   } cell_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic      le;
      entry_type entry;
   } cell_link_type;

endpackage

/* design/priority_ready_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler: thread scheduler with a sorted ready queue
// Tracks the running thread and a chain of cells holding waiting threads in
// serving order (lower priority value first, first-in first-out on ties).
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one scheduling event per item. tuser carries the event kind
//   (create, yield, terminate); tdata carries the thread id and priority of a
//   created thread.
//   rsp channel: one item per event with the running thread after the event,
//   a running flag, a status code and the number of waiting threads.
//   Result: registered; it appears on rsp in the cycle after the event is taken.
//   Throughput: one event per cycle while rsp is not stalled; every cell of
//   the chain updates in the same cycle for insert, pop and pop-then-insert.
//   A create into a full queue is refused with status full; a yield or
//   terminate with an empty queue reports status empty.
//   Reset: thread 0 with priority 1 runs and the queue is empty; no result
//   is pending.
//   Stall: while a result waits on rsp, req_tready stays low, so the block
//   holds at most one result and takes the next event as that one leaves.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler
   import prqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // new_id[7:0], priority_req[15:8]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // running_id[7:0], running_valid[8],
                                   // status[10:9], ready_count[15:11]
);

   logic                 accept;
   cell_cmd_type         cmd;
   cell_link_type        links [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] occ;

   logic [ID_W-1:0]      run_id_ff, run_id_in;
   logic [PRIO_W-1:0]    run_prio_ff, run_prio_in;
   logic                 run_valid_ff, run_valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;
   status_type           status;
   logic [ID_W-1:0]      req_id;
   logic [PRIO_W-1:0]    req_prio;
   logic                 queue_empty;
   logic                 queue_full;

   assign req_id      = req_tdata[ID_W-1:0];
   assign req_prio    = req_tdata[ID_W+PRIO_W-1:ID_W];
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   // occupancy of each slot from the fill count
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         occ[k] = (CNT_W'(k) < count_ff);
      end
   end

   // event decode: cell command, running thread and count updates
   always_comb begin
      cmd          = '{op: OP_HOLD, key: '0, fresh: '0};
      run_id_in    = run_id_ff;
      run_prio_in  = run_prio_ff;
      run_valid_in = run_valid_ff;
      count_in     = count_ff;
      status       = STATUS_OK;
      if (accept) begin
         case (func_type'(req_tuser))
            FUNC_CREATE: begin
               if (queue_full) begin
                  status = STATUS_FULL;
               end else begin
                  cmd.op         = OP_INSERT;
                  cmd.key        = req_prio;
                  cmd.fresh.id   = req_id;
                  cmd.fresh.prio = req_prio;
                  count_in       = count_ff + 1'b1;
               end
            end
            FUNC_YIELD: begin
               if (queue_empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  run_id_in    = links[0].entry.id;
                  run_prio_in  = links[0].entry.prio;
                  run_valid_in = 1'b1;
                  if (run_valid_ff) begin
                     cmd.op         = OP_POP_INSERT;
                     cmd.key        = run_prio_ff;
                     cmd.fresh.id   = run_id_ff;
                     cmd.fresh.prio = run_prio_ff;
                  end else begin
                     cmd.op   = OP_POP;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            FUNC_TERMINATE: begin
               if (queue_empty) begin
                  run_valid_in = 1'b0;
                  run_id_in    = '0;
                  run_prio_in  = '0;
                  status       = STATUS_EMPTY;
               end else begin
                  run_id_in    = links[0].entry.id;
                  run_prio_in  = links[0].entry.prio;
                  run_valid_in = 1'b1;
                  cmd.op       = OP_POP;
                  count_in     = count_ff - 1'b1;
               end
            end
            default: begin
               status = STATUS_OK;
            end
         endcase
      end
   end

   // result item built from the state after the event
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[7:0]   = run_valid_in ? run_id_in : '0;
      rsp_data_in[8]     = run_valid_in;
      rsp_data_in[10:9]  = status;
      rsp_data_in[15:11] = RCOUNT_W'(count_in);
      rsp_valid_in       = accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   // chain of queue cells
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;
      if (k == 0) begin : g_head
         assign left_link = '{le: 1'b1, entry: '0};
      end else begin : g_mid
         assign left_link = links[k-1];
      end
      if (k == QUEUE_DEPTH - 1) begin : g_tail
         assign right_link = '{le: 1'b0, entry: '0};
      end else begin : g_body
         assign right_link = links[k+1];
      end
      prqs_cell u_cell (
         .clock      (clock),
         .head       (k == 0),
         .occupied   (occ[k]),
         .cmd        (cmd),
         .left_link  (left_link),
         .right_link (right_link),
         .link       (links[k])
      );
   end

   // running thread, fill count and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         run_id_ff    <= '0;
         run_prio_ff  <= PRIO_W'(1);
         run_valid_ff <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_id_ff    <= run_id_in;
         run_prio_ff  <= run_prio_in;
         run_valid_ff <= run_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/prqs_cell.sv */
// ----------------------------------------------------------------------------
// prqs_cell: one slot of the sorted ready queue
// Holds one entry, compares it against the broadcast key and moves data to or
// from its neighbors for insert, pop and combined pop-then-insert.
// ----------------------------------------------------------------------------
module prqs_cell
   import prqs_pkg::*;
(
   input  logic          clock,
   input  logic          head,       // first cell of the chain
   input  logic          occupied,   // slot holds a live entry
   input  cell_cmd_type  cmd,
   input  cell_link_type left_link,  // neighbor nearer the head
   input  cell_link_type right_link, // neighbor nearer the tail
   output cell_link_type link
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      le;

   // entry sits at or ahead of the key in serving order
   assign le = occupied && (entry_ff.prio <= cmd.key);

   // next entry for each queue operation
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (le) begin
               entry_in = entry_ff;
            end else if (left_link.le) begin
               entry_in = cmd.fresh;
            end else begin
               entry_in = left_link.entry;
            end
         end
         OP_POP: begin
            entry_in = right_link.entry;
         end
         OP_POP_INSERT: begin
            if (right_link.le) begin
               entry_in = right_link.entry;
            end else if (head || le) begin
               entry_in = cmd.fresh;
            end else begin
               entry_in = entry_ff;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.le    = le;
   assign link.entry = entry_ff;

endmodule

/* design/prqs_checker.sv */
// ----------------------------------------------------------------------------
// prqs_checker: port-level checks for the priority ready queue scheduler
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module prqs_checker
   import prqs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // no result pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // every taken item gives a result in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("no result one cycle after an item");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // no running thread reports id zero
   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[8]) |-> (rsp_tdata[7:0] == '0))
      else $error("id shown with no running thread");

   // a refused create only happens with the queue full
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[10:9] == STATUS_FULL))
      |-> (rsp_tdata[15:11] == RCOUNT_W'(QUEUE_DEPTH)))
      else $error("full status with room in the queue");

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* sim/priority_ready_queue_checker.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_checker: scoreboard for the ready queue scheduler
// Watches the req and rsp channels, keeps its own copy of the running thread
// and the sorted ready list, predicts one result per accepted event and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module priority_ready_queue_checker
   import prqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,  // new_id[7:0], priority_req[15:8]
   input  logic [1:0]  req_tuser,  // func[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,  // running_id[7:0], running_valid[8],
                                   // status[10:9], ready_count[15:11]
   output int          pending,
   output int          failures
);
   timeunit 1ns;
   timeprecision 1ps;

   // result layout, lowest field last so it lands in the low bits
   typedef struct packed {
      logic [RCOUNT_W-1:0] ready_count;
      logic [STATUS_W-1:0] status;
      logic                running_valid;
      logic [ID_W-1:0]     running_id;
   } sched_result_type;

   // predicted scheduler state
   entry_type        running;
   logic             running_valid;
   entry_type        ready_list[$];
   sched_result_type due_results[$];
   int               fail_count = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // place behind every waiting entry with equal or lower priority value
   function automatic void ready_insert(input logic [ID_W-1:0] id,
                                        input logic [PRIO_W-1:0] prio);
      int        pos;
      entry_type e;
      e.id   = id;
      e.prio = prio;
      pos = 0;
      while (pos < ready_list.size() && ready_list[pos].prio <= prio)
         pos++;
      ready_list.insert(pos, e);
   endfunction

   function automatic void run_head();
      running       = ready_list.pop_front();
      running_valid = 1'b1;
   endfunction

   // apply one event to the predicted state and return its result
   function automatic sched_result_type schedule_event(input logic [FUNC_W-1:0] func,
                                                       input logic [ID_W-1:0]   id,
                                                       input logic [PRIO_W-1:0] prio);
      sched_result_type res;
      entry_type        prev;
      logic             had;
      status_type       st;
      st = STATUS_OK;
      case (func)
         FUNC_CREATE: begin
            if (ready_list.size() >= QUEUE_DEPTH)
               st = STATUS_FULL;
            else
               ready_insert(id, prio);
         end
         FUNC_YIELD: begin
            if (ready_list.size() == 0) begin
               st = STATUS_EMPTY;
            end else begin
               had  = running_valid;
               prev = running;
               run_head();
               if (had)
                  ready_insert(prev.id, prev.prio);
            end
         end
         FUNC_TERMINATE: begin
            if (ready_list.size() == 0) begin
               running_valid = 1'b0;
               running       = '0;
               st            = STATUS_EMPTY;
            end else begin
               run_head();
            end
         end
         // unused event kind leaves everything alone
         default: ;
      endcase
      res.running_id    = running_valid ? running.id : '0;
      res.running_valid = running_valid;
      res.status        = st;
      res.ready_count   = RCOUNT_W'(ready_list.size());
      return res;
   endfunction

   // predict on accepted events, compare on accepted results
   always @(posedge clock) begin
      sched_result_type want;
      sched_result_type got;
      if (reset) begin
         running.id    = '0;
         running.prio  = PRIO_W'(1);
         running_valid = 1'b1;
         ready_list.delete();
         due_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            due_results.push_back(schedule_event(req_tuser, req_tdata[7:0], req_tdata[15:8]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_results.size() == 0) begin
               report_mismatch("result with no event pending", int'(got), 0);
            end else begin
               want = due_results.pop_front();
               if (got.running_id !== want.running_id)
                  report_mismatch("running_id", int'(got.running_id),
                                  int'(want.running_id));
               if (got.running_valid !== want.running_valid)
                  report_mismatch("running_valid", int'(got.running_valid),
                                  int'(want.running_valid));
               if (got.status !== want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (got.ready_count !== want.ready_count)
                  report_mismatch("ready_count", int'(got.ready_count),
                                  int'(want.ready_count));
            end
         end
      end
      pending  <= due_results.size();
      failures <= fail_count;
   end

endmodule

/* sim/priority_ready_queue_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_tb: top level for the scheduler testbench
// Drives directed and random scheduling events with random gaps and result
// stalls; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_tb
   import prqs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_EVENTS = 1200;
   localparam int IDLE_LIMIT    = 200;
   localparam int DRAIN_CYCLES  = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // new_id[7:0], priority_req[15:8]
   logic [1:0]  req_tuser  = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // running_id[7:0], running_valid[8],
                                   // status[10:9], ready_count[15:11]
   int          pending;
   int          failures;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   logic        req_no_gap  = 1'b0;
   logic        rsp_no_stall = 1'b0;

   always #10 clock = ~clock;

   priority_ready_queue_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   priority_ready_queue_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .pending    (pending),
      .failures   (failures)
   );

   // present one event after a random gap and hold it until taken
   task automatic send_event(input logic [FUNC_W-1:0] func,
                             input logic [ID_W-1:0]   id,
                             input logic [PRIO_W-1:0] prio);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, id};
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // result side: random stall after each item, with stall-free stretches
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(0, 49) == 0)
            rsp_no_stall <= ~rsp_no_stall;
         hold = rsp_no_stall ? 0 : $urandom_range(0, 4);
         rsp_tready <= (hold == 0);
         stall_left <= hold;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("priority_ready_queue_scheduler_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                mix;
      int                pick;
      int                create_pct;
      int                term_pct;
      logic [FUNC_W-1:0] func;
      logic [PRIO_W-1:0] prio;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, unused kind, extremes, ties, no running thread
      send_event(FUNC_YIELD,     8'h00, 8'h00);
      send_event(FUNC_UNUSED,    8'hFF, 8'hFF);
      send_event(FUNC_CREATE,    8'hFF, 8'hFF);
      send_event(FUNC_CREATE,    8'h00, 8'h00);
      send_event(FUNC_CREATE,    8'h11, 8'h07);
      send_event(FUNC_CREATE,    8'h22, 8'h07);
      send_event(FUNC_CREATE,    8'h33, 8'h07);
      send_event(FUNC_YIELD,     8'hA5, 8'h5A);
      send_event(FUNC_TERMINATE, 8'h5A, 8'hA5);
      send_event(FUNC_TERMINATE, 8'h00, 8'h00);
      send_event(FUNC_TERMINATE, 8'h00, 8'h00);
      send_event(FUNC_TERMINATE, 8'h00, 8'h00);
      send_event(FUNC_TERMINATE, 8'h00, 8'h00);
      send_event(FUNC_TERMINATE, 8'h00, 8'h00);
      send_event(FUNC_TERMINATE, 8'hFF, 8'hFF);
      send_event(FUNC_YIELD,     8'h00, 8'h00);
      send_event(FUNC_CREATE,    8'hAA, 8'h80);
      send_event(FUNC_YIELD,     8'h00, 8'h00);
      send_event(FUNC_TERMINATE, 8'h00, 8'h00);
      send_event(FUNC_CREATE,    8'h55, 8'h01);
      send_event(FUNC_TERMINATE, 8'h00, 8'h00);
      send_event(FUNC_CREATE,    8'hC3, 8'h3C);
      send_event(FUNC_UNUSED,    8'h00, 8'h00);

      // random: phases that lean toward filling, draining or a mix
      for (int n = 0; n < RANDOM_EVENTS; n++) begin
         if (n % 40 == 0) begin
            mix        = $urandom_range(0, 2);
            req_no_gap <= ($urandom_range(0, 3) == 0);
         end
         create_pct = (mix == 0) ? 75 : (mix == 1) ? 20 : 40;
         term_pct   = (mix == 0) ? 10 : (mix == 1) ? 50 : 25;
         pick = $urandom_range(0, 99);
         if (pick < 2)
            func = FUNC_UNUSED;
         else if (pick < 2 + create_pct)
            func = FUNC_CREATE;
         else if (pick < 2 + create_pct + term_pct)
            func = FUNC_TERMINATE;
         else
            func = FUNC_YIELD;
         // narrow priorities give plenty of ties
         case ($urandom_range(0, 3))
            0, 1:    prio = PRIO_W'($urandom_range(0, 3));
            2:       prio = PRIO_W'($urandom_range(0, 255));
            default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         endcase
         send_event(func, ID_W'($urandom_range(0, 255)), prio);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("priority_ready_queue_scheduler_tb OK");
      else
         $display("priority_ready_queue_scheduler_tb NOT OK");
      $finish;
   end

endmodule
